// ----- rtl/hsfu_pkg.sv -----
`default_nettype none

package hsfu_pkg;

    // Field widths
    localparam int GRAD_W   = 13;
    localparam int FLOW_W   = 16;
    localparam int WEIGHT_W = 24;

    // Smoothness weight after reset: 0.4 in Q16.8
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(102);

    // Derived arithmetic widths
    localparam int PROD_W   = GRAD_W + FLOW_W;          // grad * flow, signed
    localparam int NUM_W    = PROD_W + 1;               // numerator, signed
    localparam int NMAG_W   = NUM_W - 1;                // |numerator|
    localparam int SQ_W     = 2 * GRAD_W - 1;           // grad squared
    localparam int SQSUM_W  = SQ_W + 1;                 // sum of two squares
    localparam int DEN_W    = ((SQSUM_W + 8 > WEIGHT_W) ? SQSUM_W + 8 : WEIGHT_W) + 1;
    localparam int MPROD_W  = GRAD_W + NMAG_W;          // |grad| * |num|
    localparam int DVD_W    = MPROD_W + 8;              // dividend, scaled by 256
    localparam int Q_W      = FLOW_W + 2;               // quotient bits kept
    localparam int DIV_W    = DEN_W + Q_W;              // partial remainder
    localparam int RES_W    = Q_W + 3;                  // average minus correction

    // Saturation bounds in the result width
    localparam logic signed [RES_W-1:0] FLOW_MAX =
        RES_W'((64'sd1 <<< (FLOW_W - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] FLOW_MIN = -FLOW_MAX - RES_W'(1);

    // One pixel on the input channel
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_t;
        logic signed [FLOW_W-1:0] u_avg;
        logic signed [FLOW_W-1:0] v_avg;
    } pix_item_t;

    // One pixel inside the divider pipeline
    typedef struct packed {
        logic                     zero_den;
        logic                     clamp_u;
        logic                     clamp_v;
        logic                     neg_u;
        logic                     neg_v;
        logic signed [FLOW_W-1:0] u_avg;
        logic signed [FLOW_W-1:0] v_avg;
        logic [DEN_W-1:0]         den;
        logic [DIV_W-1:0]         rem_u;
        logic [DIV_W-1:0]         rem_v;
        logic [Q_W-1:0]           quo_u;
        logic [Q_W-1:0]           quo_v;
    } div_item_t;

    // One result on the output channel
    typedef struct packed {
        logic signed [FLOW_W-1:0] u_new;
        logic signed [FLOW_W-1:0] v_new;
        logic                     zero_denominator;
        logic                     saturated;
    } flow_item_t;

endpackage

`default_nettype wire

// ----- rtl/hsfu_if.sv -----
`default_nettype none

// Pixel channel: derivatives and flow averages
interface hsfu_pix_if import hsfu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_t;
    logic signed [FLOW_W-1:0] u_avg;
    logic signed [FLOW_W-1:0] v_avg;

    modport source (output valid, output grad_x, output grad_y, output grad_t,
                    output u_avg, output v_avg, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input grad_t,
                    input u_avg, input v_avg, output ready);
endinterface

// Flow channel: updated flow and flags
interface hsfu_flow_if import hsfu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [FLOW_W-1:0] u_new;
    logic signed [FLOW_W-1:0] v_new;
    logic                     zero_denominator;
    logic                     saturated;

    modport source (output valid, output u_new, output v_new,
                    output zero_denominator, output saturated, input ready);
    modport sink   (input valid, input u_new, input v_new,
                    input zero_denominator, input saturated, output ready);
endinterface

// Configuration channel: smoothness weight write data
interface hsfu_cfg_if import hsfu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsfu_front.sv -----
`default_nettype none

module hsfu_front import hsfu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic                in_valid,
    input  wire pix_item_t           in_item,
    output logic                     out_valid,
    output div_item_t                out_item
);

    // Stage 1: products and squares
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_pxu_reg;
    logic signed [PROD_W-1:0] s1_pyv_reg;
    logic [SQ_W-1:0]          s1_sqx_reg;
    logic [SQ_W-1:0]          s1_sqy_reg;
    logic signed [GRAD_W-1:0] s1_gx_reg;
    logic signed [GRAD_W-1:0] s1_gy_reg;
    logic signed [GRAD_W-1:0] s1_gt_reg;
    logic signed [FLOW_W-1:0] s1_ua_reg;
    logic signed [FLOW_W-1:0] s1_va_reg;

    logic signed [PROD_W-1:0]   s1_pxu_next;
    logic signed [PROD_W-1:0]   s1_pyv_next;
    logic signed [2*GRAD_W-1:0] sqx_full;
    logic signed [2*GRAD_W-1:0] sqy_full;

    assign s1_pxu_next = PROD_W'(in_item.grad_x) * PROD_W'(in_item.u_avg);
    assign s1_pyv_next = PROD_W'(in_item.grad_y) * PROD_W'(in_item.v_avg);
    assign sqx_full    = (2*GRAD_W)'(in_item.grad_x) * (2*GRAD_W)'(in_item.grad_x);
    assign sqy_full    = (2*GRAD_W)'(in_item.grad_y) * (2*GRAD_W)'(in_item.grad_y);

    // Stage 2: numerator and denominator
    logic                     s2_valid_reg;
    logic signed [NUM_W-1:0]  s2_num_reg;
    logic [DEN_W-1:0]         s2_den_reg;
    logic signed [GRAD_W-1:0] s2_gx_reg;
    logic signed [GRAD_W-1:0] s2_gy_reg;
    logic signed [FLOW_W-1:0] s2_ua_reg;
    logic signed [FLOW_W-1:0] s2_va_reg;

    logic signed [NUM_W-1:0]  s2_num_next;
    logic [DEN_W-1:0]         s2_den_next;
    logic [SQSUM_W-1:0]       sq_sum;
    logic signed [GRAD_W+7:0] gt_scaled;

    assign gt_scaled   = signed'({s1_gt_reg, 8'b0});
    assign s2_num_next = NUM_W'(s1_pxu_reg) + NUM_W'(s1_pyv_reg) + NUM_W'(gt_scaled);
    assign sq_sum      = SQSUM_W'(s1_sqx_reg) + SQSUM_W'(s1_sqy_reg);
    assign s2_den_next = DEN_W'(weight) + (DEN_W'(sq_sum) << 8);

    // Stage 3: magnitudes, signs and the grad * num products
    logic                     s3_valid_reg;
    logic [MPROD_W-1:0]       s3_prod_u_reg;
    logic [MPROD_W-1:0]       s3_prod_v_reg;
    logic [DEN_W-1:0]         s3_den_reg;
    logic                     s3_neg_u_reg;
    logic                     s3_neg_v_reg;
    logic                     s3_zero_reg;
    logic signed [FLOW_W-1:0] s3_ua_reg;
    logic signed [FLOW_W-1:0] s3_va_reg;

    logic [NUM_W-1:0]         num_abs;
    logic [GRAD_W-1:0]        gx_abs;
    logic [GRAD_W-1:0]        gy_abs;
    logic [MPROD_W-1:0]       s3_prod_u_next;
    logic [MPROD_W-1:0]       s3_prod_v_next;

    assign num_abs = s2_num_reg[NUM_W-1] ? NUM_W'(-s2_num_reg) : NUM_W'(s2_num_reg);
    assign gx_abs  = s2_gx_reg[GRAD_W-1] ? GRAD_W'(-s2_gx_reg) : GRAD_W'(s2_gx_reg);
    assign gy_abs  = s2_gy_reg[GRAD_W-1] ? GRAD_W'(-s2_gy_reg) : GRAD_W'(s2_gy_reg);
    assign s3_prod_u_next = MPROD_W'(gx_abs) * MPROD_W'(num_abs[NMAG_W-1:0]);
    assign s3_prod_v_next = MPROD_W'(gy_abs) * MPROD_W'(num_abs[NMAG_W-1:0]);

    // Stage 4: scale the dividends and check quotient overflow
    logic                     s4_valid_reg;
    div_item_t                s4_item_reg;
    div_item_t                s4_item_next;
    logic [DVD_W-1:0]         dvd_u;
    logic [DVD_W-1:0]         dvd_v;
    logic [DIV_W-1:0]         den_top;

    assign dvd_u   = {s3_prod_u_reg, 8'b0};
    assign dvd_v   = {s3_prod_v_reg, 8'b0};
    assign den_top = {s3_den_reg, Q_W'(0)};

    always_comb
    begin
        s4_item_next          = '0;
        s4_item_next.zero_den = s3_zero_reg;
        s4_item_next.clamp_u  = DIV_W'(dvd_u) >= den_top;
        s4_item_next.clamp_v  = DIV_W'(dvd_v) >= den_top;
        s4_item_next.neg_u    = s3_neg_u_reg;
        s4_item_next.neg_v    = s3_neg_v_reg;
        s4_item_next.u_avg    = s3_ua_reg;
        s4_item_next.v_avg    = s3_va_reg;
        s4_item_next.den      = s3_den_reg;
        s4_item_next.rem_u    = DIV_W'(dvd_u);
        s4_item_next.rem_v    = DIV_W'(dvd_v);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pxu_reg    <= s1_pxu_next;
            s1_pyv_reg    <= s1_pyv_next;
            s1_sqx_reg    <= sqx_full[SQ_W-1:0];
            s1_sqy_reg    <= sqy_full[SQ_W-1:0];
            s1_gx_reg     <= in_item.grad_x;
            s1_gy_reg     <= in_item.grad_y;
            s1_gt_reg     <= in_item.grad_t;
            s1_ua_reg     <= in_item.u_avg;
            s1_va_reg     <= in_item.v_avg;

            s2_num_reg    <= s2_num_next;
            s2_den_reg    <= s2_den_next;
            s2_gx_reg     <= s1_gx_reg;
            s2_gy_reg     <= s1_gy_reg;
            s2_ua_reg     <= s1_ua_reg;
            s2_va_reg     <= s1_va_reg;

            s3_prod_u_reg <= s3_prod_u_next;
            s3_prod_v_reg <= s3_prod_v_next;
            s3_den_reg    <= s2_den_reg;
            s3_neg_u_reg  <= s2_gx_reg[GRAD_W-1] ^ s2_num_reg[NUM_W-1];
            s3_neg_v_reg  <= s2_gy_reg[GRAD_W-1] ^ s2_num_reg[NUM_W-1];
            s3_zero_reg   <= (s2_den_reg == '0);
            s3_ua_reg     <= s2_ua_reg;
            s3_va_reg     <= s2_va_reg;

            s4_item_reg   <= s4_item_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

`default_nettype wire

// ----- rtl/hsfu_div_stage.sv -----
`default_nettype none

module hsfu_div_stage import hsfu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire div_item_t in_item,
    output logic           out_valid,
    output div_item_t      out_item
);

    logic          valid_reg;
    div_item_t     item_reg;
    div_item_t     item_next;
    logic [DIV_W-1:0] den_shifted;
    logic [DIV_W-1:0] sub_u;
    logic [DIV_W-1:0] sub_v;
    logic          ge_u;
    logic          ge_v;

    // Divisor aligned to the top quotient bit; the remainder shifts past it
    assign den_shifted = {1'b0, in_item.den, (Q_W-1)'(0)};

    // Retire one quotient bit per lane
    always_comb
    begin
        ge_u  = in_item.rem_u >= den_shifted;
        ge_v  = in_item.rem_v >= den_shifted;
        sub_u = ge_u ? in_item.rem_u - den_shifted : in_item.rem_u;
        sub_v = ge_v ? in_item.rem_v - den_shifted : in_item.rem_v;

        item_next       = in_item;
        item_next.rem_u = {sub_u[DIV_W-2:0], 1'b0};
        item_next.rem_v = {sub_v[DIV_W-2:0], 1'b0};
        item_next.quo_u = {in_item.quo_u[Q_W-2:0], ge_u};
        item_next.quo_v = {in_item.quo_v[Q_W-2:0], ge_v};
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- rtl/hsfu_back.sv -----
`default_nettype none

module hsfu_back import hsfu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire div_item_t in_item,
    input  wire logic      out_ready,
    output logic           out_valid,
    output flow_item_t     out_item,
    output logic           en
);

    // Apply a signed correction to an average and clip; bit FLOW_W flags a clip
    function automatic logic [FLOW_W:0] apply_corr(
        input logic signed [FLOW_W-1:0] avg,
        input logic                     clamp,
        input logic                     neg,
        input logic [Q_W-1:0]           quo
    );
        logic [Q_W:0]             mag;
        logic signed [RES_W-1:0]  corr;
        logic signed [RES_W-1:0]  diff;
        logic [FLOW_W:0]          res;
        mag  = clamp ? {1'b1, Q_W'(0)} : {1'b0, quo};
        corr = signed'(RES_W'(mag));
        diff = RES_W'(avg) + (neg ? corr : -corr);
        if (diff > FLOW_MAX)
        begin
            res = {1'b1, FLOW_MAX[FLOW_W-1:0]};
        end
        else if (diff < FLOW_MIN)
        begin
            res = {1'b1, FLOW_MIN[FLOW_W-1:0]};
        end
        else
        begin
            res = {1'b0, diff[FLOW_W-1:0]};
        end
        return res;
    endfunction

    logic             out_valid_reg;
    logic             out_valid_next;
    flow_item_t       out_reg;
    flow_item_t       out_next;
    logic             skid_full_reg;
    logic             skid_full_next;
    flow_item_t       skid_reg;
    flow_item_t       skid_next;
    flow_item_t       result;
    logic [FLOW_W:0]  res_u;
    logic [FLOW_W:0]  res_v;

    // Form the final flow values
    always_comb
    begin
        res_u = apply_corr(in_item.u_avg, in_item.clamp_u, in_item.neg_u, in_item.quo_u);
        res_v = apply_corr(in_item.v_avg, in_item.clamp_v, in_item.neg_v, in_item.quo_v);
        if (in_item.zero_den)
        begin
            result.u_new            = in_item.u_avg;
            result.v_new            = in_item.v_avg;
            result.zero_denominator = 1'b1;
            result.saturated        = 1'b0;
        end
        else
        begin
            result.u_new            = signed'(res_u[FLOW_W-1:0]);
            result.v_new            = signed'(res_v[FLOW_W-1:0]);
            result.zero_denominator = 1'b0;
            result.saturated        = res_u[FLOW_W] | res_v[FLOW_W];
        end
    end

    // Pipeline moves only while the skid slot is free
    assign en = !skid_full_reg;

    // Output register with a skid slot behind it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (skid_full_reg)
        begin
            if (out_ready)
            begin
                skid_full_next = 1'b0;
            end
        end
        else
        begin
            // Park an untaken result and take the next one
            if (out_valid_reg && !out_ready)
            begin
                skid_full_next = 1'b1;
                skid_next      = out_reg;
            end
            out_valid_next = in_valid;
            if (in_valid)
            begin
                out_next = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Skid slot holds the older result
    assign out_valid = skid_full_reg | out_valid_reg;
    assign out_item  = skid_full_reg ? skid_reg : out_reg;

endmodule

`default_nettype wire

// ----- rtl/horn_schunck_flow_update_core.sv -----
// Channel  Dir  Payload                                            Moves when
// -------  ---  -------------------------------------------------  -------------
// pixel    in   grad_x, grad_y, grad_t, u_avg, v_avg               valid & ready
// flow     out  u_new, v_new, zero_denominator, saturated          valid & ready
// cfg      in   data (smoothness weight, unsigned Q16.8)           valid & ready
//
// One pixel per clock while the skid slot is empty. From accept to flow valid a pixel passes four
// arithmetic stages, one stage per quotient bit (18) of the two restoring
// dividers running side by side, and the output register.
// Reset clears all valid bits and loads the smoothness weight with 0.4.
// A stalled result moves to a skid slot; while it is occupied the whole
// pipeline holds and pixel.ready is low. cfg.ready is always high.
`default_nettype none

module horn_schunck_flow_update_core import hsfu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hsfu_pix_if.sink   pixel,
    hsfu_flow_if.source flow,
    hsfu_cfg_if.sink   cfg
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic                en;
    pix_item_t           pix_item;
    flow_item_t          flow_item;

    logic                div_valid [Q_W+1];
    div_item_t           div_item  [Q_W+1];

    // Hold the smoothness weight
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            weight_reg <= cfg.data;
        end
    end

    // Gather the pixel fields
    assign pix_item.grad_x = pixel.grad_x;
    assign pix_item.grad_y = pixel.grad_y;
    assign pix_item.grad_t = pixel.grad_t;
    assign pix_item.u_avg  = pixel.u_avg;
    assign pix_item.v_avg  = pixel.v_avg;
    assign pixel.ready     = en;

    hsfu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .weight    (weight_reg),
        .in_valid  (pixel.valid),
        .in_item   (pix_item),
        .out_valid (div_valid[0]),
        .out_item  (div_item[0])
    );

    // One quotient bit per stage
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        hsfu_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_item   (div_item[k]),
            .out_valid (div_valid[k+1]),
            .out_item  (div_item[k+1])
        );
    end

    hsfu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[Q_W]),
        .in_item   (div_item[Q_W]),
        .out_ready (flow.ready),
        .out_valid (flow.valid),
        .out_item  (flow_item),
        .en        (en)
    );

    // Drive the flow fields
    assign flow.u_new            = flow_item.u_new;
    assign flow.v_new            = flow_item.v_new;
    assign flow.zero_denominator = flow_item.zero_denominator;
    assign flow.saturated        = flow_item.saturated;

endmodule

`default_nettype wire
